/* sv/rcp_pkg.sv */
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types and codes for the rectangle canvas painter.
// ----------------------------------------------------------------------------
package rcp_pkg;

  // Stream payload widths (bytes, zero padded)
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 16;

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_CHAR = 2'd2;

  // Reset values of the config registers
  localparam logic [8:0] CANVAS_SIDE_RST = 9'd1;
  localparam logic [7:0] BACKGROUND_RST  = 8'd32;

  // Ops
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Rectangle kinds
  localparam logic [7:0] KIND_OUTLINE = 8'h72;  // 'r'
  localparam logic [7:0] KIND_FILLED  = 8'h52;  // 'R'

  // Coordinate compare width: covers Q15.8 sums and pixel coordinates up to
  // 1023 << 16, signed.
  localparam int COORD_W = 28;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Bounds of the rectangle along one axis
  typedef struct packed {
    coord_t lo;      // left/top edge
    coord_t hi;      // edge + size
    coord_t lo_one;  // lo + one unit
    coord_t hi_one;  // hi - one unit
  } axis_bounds_t;

  // Compare result along one axis
  typedef struct packed {
    logic in_span;
    logic on_edge;
  } axis_hit_t;

endpackage

/* sv/rectangle_canvas_painter_core.sv */
// ----------------------------------------------------------------------------
// rectangle_canvas_painter_core
// Byte canvas with clear, rectangle fill/outline draw and pixel read.
//
// Every input transfer gives exactly one result transfer. Clear and draw
// sweep the canvas in use one pixel per cycle, row by row, through a single
// RAM port, after a setup state for a draw; a rejected draw skips the sweep.
// A read computes the address, accesses the RAM and captures the data; every
// op, unused ones too, ends in a hand-off state to the output register.
// s_tready is high only while the sequencer is idle; a finished result
// sits in the output register and the next item can be taken meanwhile.
// The canvas RAM is not cleared at reset: issue a clear before reading.
// Config writes must only happen while the block is idle.
// ----------------------------------------------------------------------------
module rectangle_canvas_painter_core
  import rcp_pkg::*;
#(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata, from bit 0: op[2], rect_kind[8], x_pos[24], y_pos[24],
  // rect_w[24], rect_h[24], paint_char[8], read_x[8], read_y[8], zero pad[6]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata, from bit 0: status[1], pixel[8], zero pad[7]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;     // RAM address
  localparam int XW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1; // counters
  localparam int SW    = $clog2(MAX_SIDE + 1);                // side values
  localparam int PW    = 8 + SW;                              // read product
  localparam coord_t ONE_UNIT = COORD_W'(64'd1 << FRAC_BITS);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;  // draw: finish bounds, check
  localparam logic [2:0] ST_SWEEP = 3'd2;  // clear/draw pixel walk
  localparam logic [2:0] ST_RADDR = 3'd3;  // read: address compute
  localparam logic [2:0] ST_RREAD = 3'd4;  // read: RAM access
  localparam logic [2:0] ST_RDATA = 3'd5;  // read: capture data
  localparam logic [2:0] ST_DONE  = 3'd6;  // hand result to output reg

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [8:0] canvas_width;
  logic [8:0] canvas_height;
  logic [7:0] background_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= CANVAS_SIDE_RST;
      canvas_height   <= CANVAS_SIDE_RST;
      background_char <= BACKGROUND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CANVAS_WIDTH:    canvas_width    <= cfg_data;
        CFG_CANVAS_HEIGHT:   canvas_height   <= cfg_data;
        CFG_BACKGROUND_CHAR: background_char <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective sides: zero reads as 1, oversize clamps to MAX_SIDE
  logic [SW-1:0] w_eff;
  logic [SW-1:0] h_eff;

  always_comb begin
    if (canvas_width == '0) begin
      w_eff = SW'(1);
    end else if (32'(canvas_width) > MAX_SIDE) begin
      w_eff = SW'(MAX_SIDE);
    end else begin
      w_eff = SW'(canvas_width);
    end
    if (canvas_height == '0) begin
      h_eff = SW'(1);
    end else if (32'(canvas_height) > MAX_SIDE) begin
      h_eff = SW'(MAX_SIDE);
    end else begin
      h_eff = SW'(canvas_height);
    end
  end

  // --------------------------------------------------------------------------
  // Input field unpack
  // --------------------------------------------------------------------------
  logic        [1:0]  in_op;
  logic        [7:0]  in_kind;
  logic signed [23:0] in_x;
  logic signed [23:0] in_y;
  logic signed [23:0] in_w;
  logic signed [23:0] in_h;
  logic        [7:0]  in_paint;
  logic        [7:0]  in_read_x;
  logic        [7:0]  in_read_y;

  assign in_op     = s_tdata[1:0];
  assign in_kind   = s_tdata[9:2];
  assign in_x      = s_tdata[33:10];
  assign in_y      = s_tdata[57:34];
  assign in_w      = s_tdata[81:58];
  assign in_h      = s_tdata[105:82];
  assign in_paint  = s_tdata[113:106];
  assign in_read_x = s_tdata[121:114];
  assign in_read_y = s_tdata[129:122];

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  logic [2:0]    state;
  logic          in_xfer;

  // captured item (payload, no reset)
  logic [1:0]    op_q;
  logic          filled_q;
  logic          reject_q;
  logic [7:0]    paint_q;
  logic [7:0]    read_x_q;
  logic [7:0]    read_y_q;
  axis_bounds_t  bnd_x;
  axis_bounds_t  bnd_y;

  // sweep counters
  logic [XW-1:0] x_cnt;
  logic [XW-1:0] y_cnt;
  logic [AW-1:0] row_base;
  logic          last_x;
  logic          last_y;

  // read path
  logic          rd_ok;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] rd_sum;

  // result staging and output register
  logic          res_status;
  logic [7:0]    res_pixel;
  logic          out_status;
  logic [7:0]    out_pixel;
  logic          out_free;

  // RAM side
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // compare unit
  coord_t        px;
  coord_t        py;
  axis_hit_t     hit_x;
  axis_hit_t     hit_y;
  logic          pix_hit;

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign last_x = (32'(x_cnt) + 1 == 32'(w_eff));
  assign last_y = (32'(y_cnt) + 1 == 32'(h_eff));

  // Pixel centers on the Q grid
  assign px = $signed(COORD_W'(x_cnt) << FRAC_BITS);
  assign py = $signed(COORD_W'(y_cnt) << FRAC_BITS);

  rcp_axis_cmp u_cmp_x (
    .bnd (bnd_x),
    .pos (px),
    .hit (hit_x)
  );

  rcp_axis_cmp u_cmp_y (
    .bnd (bnd_y),
    .pos (py),
    .hit (hit_y)
  );

  // Filled: anything inside. Outline: inside and near any edge.
  assign pix_hit = hit_x.in_span && hit_y.in_span &&
                   (filled_q || hit_x.on_edge || hit_y.on_edge);

  // Read address: row * width + column, range checked against current sides
  assign rd_sum = PW'(read_y_q) * PW'(w_eff) + PW'(read_x_q);

  // Single RAM port: sweep writes or the one read
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = row_base + AW'(x_cnt);
    ram_wdata = paint_q;
    if (state == ST_SWEEP) begin
      if (op_q == OP_CLEAR) begin
        ram_we    = 1'b1;
        ram_wdata = background_char;
      end else begin
        ram_we    = pix_hit;
      end
    end else if (state == ST_RREAD) begin
      ram_re   = rd_ok;
      ram_addr = rd_addr;
    end
  end

  rcp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (in_op)
              OP_CLEAR: state <= ST_SWEEP;
              OP_DRAW:  state <= ST_SETUP;
              OP_READ:  state <= ST_RADDR;
              default:  state <= ST_DONE;
            endcase
          end
        end
        ST_SETUP: state <= reject_q ? ST_DONE : ST_SWEEP;
        ST_SWEEP: begin
          if (last_x && last_y) begin
            state <= ST_DONE;
          end
        end
        ST_RADDR: state <= ST_RREAD;
        ST_RREAD: state <= ST_RDATA;
        ST_RDATA: state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          op_q       <= in_op;
          filled_q   <= (in_kind == KIND_FILLED);
          reject_q   <= (in_w <= 0) || (in_h <= 0) ||
                        ((in_kind != KIND_FILLED) && (in_kind != KIND_OUTLINE));
          paint_q    <= in_paint;
          read_x_q   <= in_read_x;
          read_y_q   <= in_read_y;
          bnd_x.lo     <= COORD_W'(in_x);
          bnd_x.hi     <= COORD_W'(in_x) + COORD_W'(in_w);
          bnd_x.lo_one <= COORD_W'(in_x) + ONE_UNIT;
          bnd_y.lo     <= COORD_W'(in_y);
          bnd_y.hi     <= COORD_W'(in_y) + COORD_W'(in_h);
          bnd_y.lo_one <= COORD_W'(in_y) + ONE_UNIT;
          x_cnt      <= '0;
          y_cnt      <= '0;
          row_base   <= '0;
          res_status <= 1'b0;
          res_pixel  <= '0;
        end
      end
      ST_SETUP: begin
        bnd_x.hi_one <= bnd_x.hi - ONE_UNIT;
        bnd_y.hi_one <= bnd_y.hi - ONE_UNIT;
        res_status   <= reject_q;
      end
      ST_SWEEP: begin
        if (last_x) begin
          x_cnt    <= '0;
          y_cnt    <= y_cnt + XW'(1);
          row_base <= row_base + AW'(w_eff);
        end else begin
          x_cnt    <= x_cnt + XW'(1);
        end
      end
      ST_RADDR: begin
        rd_ok   <= (32'(read_x_q) < 32'(w_eff)) && (32'(read_y_q) < 32'(h_eff));
        rd_addr <= AW'(rd_sum);
      end
      ST_RDATA: begin
        res_pixel <= rd_ok ? ram_rdata : 8'd0;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_status <= res_status;
      out_pixel  <= res_pixel;
    end
  end

  assign m_tdata = {7'd0, out_pixel, out_status};

`ifndef ASSERT_OFF
  // The canvas is only written during a sweep
  a_we_in_sweep: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_SWEEP))
    else $error("canvas written outside sweep");

  // Sweep counters stay inside the canvas in use
  a_sweep_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (32'(x_cnt) < 32'(w_eff)) && (32'(y_cnt) < 32'(h_eff)))
    else $error("sweep counter out of canvas");

  // A result hand-off always shows up on the output
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_free |=> m_tvalid && (state == ST_IDLE))
    else $error("result not presented");

  // Only a draw can be rejected
  a_reject_draw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && res_status |-> (op_q == OP_DRAW))
    else $error("error status on non-draw op");

  // Each accepted item leaves idle at once
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != ST_IDLE))
    else $error("accepted item not started");
`endif

endmodule

/* sv/rcp_ram.sv */
// ----------------------------------------------------------------------------
// rcp_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module rcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/rcp_axis_cmp.sv */
// ----------------------------------------------------------------------------
// rcp_axis_cmp
// Compare unit for one axis: inside the closed span, and within one unit
// of either edge.
// ----------------------------------------------------------------------------
module rcp_axis_cmp
  import rcp_pkg::*;
(
  input  axis_bounds_t bnd,
  input  coord_t       pos,
  output axis_hit_t    hit
);

  always_comb begin
    hit.in_span = (bnd.lo <= pos) && (pos <= bnd.hi);
    hit.on_edge = (pos < bnd.lo_one) || (pos > bnd.hi_one);
  end

endmodule

/* verif/rectangle_canvas_painter_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rectangle_canvas_painter_core_tb
// Self-checking bench for the canvas painter: drives clear, draw, read and
// unused-op commands through the input stream, tracks the canvas contents
// on the side and checks every result transfer against that shadow copy.
// Runs several canvas settings (degenerate, odd, full size) under varying
// sender idling, receiver back-pressure and one long output hold-off.
// ----------------------------------------------------------------------------
module rectangle_canvas_painter_core_tb;
  import rcp_pkg::*;

  localparam int  CLK_PERIOD      = 8;
  localparam int  UNIT            = 256;     // 1.0 in Q15.8
  localparam int  STORE_SIZE      = 65536;
  localparam int  WATCHDOG_LIMIT  = 300000;  // longer than a full 256x256 sweep
  localparam int  HOLD_OFF_CYCLES = 4000;    // outlasts a 31x17 sweep
  localparam int  MAX_REPORTS     = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Command layout, LSB first: op, kind, x, y, w, h, paint, read_x, read_y
  typedef struct packed {
    logic [7:0]  read_y;
    logic [7:0]  read_x;
    logic [7:0]  paint_char;
    logic [23:0] rect_h;
    logic [23:0] rect_w;
    logic [23:0] y_pos;
    logic [23:0] x_pos;
    logic [7:0]  rect_kind;
    logic [1:0]  op;
  } canvas_cmd_t;

  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] pixel;
    logic       status;
  } canvas_result_t;

  // --------------------------------------------------------------------------
  // Shadow canvas: replays every accepted command and queues the result
  // the block owes for it.
  // --------------------------------------------------------------------------
  class canvas_tracker;
    bit [7:0]       canvas_px [STORE_SIZE];
    bit             px_written[STORE_SIZE];
    bit [8:0]       width_reg;
    bit [8:0]       height_reg;
    bit [7:0]       bg_reg;
    canvas_result_t pending_results[$];
    int             error_count;

    function new();
      width_reg   = CANVAS_SIDE_RST;
      height_reg  = CANVAS_SIDE_RST;
      bg_reg      = BACKGROUND_RST;
      error_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CANVAS_WIDTH:    width_reg  = data;
        CFG_CANVAS_HEIGHT:   height_reg = data;
        CFG_BACKGROUND_CHAR: bg_reg     = data[7:0];
        default: ;
      endcase
    endfunction

    // zero counts as one, anything past 256 is clamped
    function int side(bit [8:0] reg_val);
      if (reg_val == 0) return 1;
      if (reg_val > 256) return 256;
      return reg_val;
    endfunction

    // true when a read at (qx, qy) never touches an unwritten cell
    function bit readable(int qx, int qy);
      int w, h;
      w = side(width_reg);
      h = side(height_reg);
      if (qx >= w || qy >= h) return 1;
      return px_written[qy * w + qx];
    endfunction

    function void note_command(canvas_cmd_t c);
      canvas_result_t r;
      int w, h;
      longint rx, ry, rw, rh, right, bottom, px, py;
      bit edge_y, hit;
      w = side(width_reg);
      h = side(height_reg);
      r = '0;
      case (c.op)
        OP_CLEAR: begin
          for (int i = 0; i < w * h; i++) begin
            canvas_px[i]  = bg_reg;
            px_written[i] = 1'b1;
          end
        end
        OP_DRAW: begin
          rx = $signed(c.x_pos);
          ry = $signed(c.y_pos);
          rw = $signed(c.rect_w);
          rh = $signed(c.rect_h);
          if (rw <= 0 || rh <= 0 ||
              (c.rect_kind != KIND_OUTLINE && c.rect_kind != KIND_FILLED)) begin
            r.status = 1'b1;
          end else begin
            right  = rx + rw;
            bottom = ry + rh;
            for (int y = 0; y < h; y++) begin
              py = longint'(y) * UNIT;
              if (!(ry <= py && py <= bottom)) continue;
              edge_y = (py < ry + UNIT) || (py > bottom - UNIT);
              for (int x = 0; x < w; x++) begin
                px = longint'(x) * UNIT;
                if (!(rx <= px && px <= right)) continue;
                hit = (c.rect_kind == KIND_FILLED) || edge_y ||
                      (px < rx + UNIT) || (px > right - UNIT);
                if (hit) begin
                  canvas_px[y * w + x]  = c.paint_char;
                  px_written[y * w + x] = 1'b1;
                end
              end
            end
          end
        end
        OP_READ: begin
          if (c.read_x < w && c.read_y < h) r.pixel = canvas_px[c.read_y * w + c.read_x];
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void flag(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    function void compare_result(logic [OUT_DATA_W-1:0] data);
      canvas_result_t got, want;
      got = data;
      if (pending_results.size() == 0) begin
        flag($sformatf("unexpected result transfer, data %04h", data));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.pixel !== want.pixel)
        flag($sformatf("expected status %0d pixel %02h, got status %0d pixel %02h",
                       want.status, want.pixel, got.status, got.pixel));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // op, kind, x, y, w, h, paint, read_x, read_y
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // status, pixel

  canvas_tracker tracker;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off_request;
  int stall_cycles;

  rectangle_canvas_painter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Receiver: random back-pressure, or a long hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left        = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) tracker.compare_result(m_tdata);
  end

  // Watchdog: cycles with no transfer on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("rectangle_canvas_painter_core_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic canvas_cmd_t make_cmd(logic [1:0] op, logic [7:0] kind,
                                           int x, int y, int w, int h,
                                           logic [7:0] paint, int qx, int qy);
    canvas_cmd_t c;
    c.op         = op;
    c.rect_kind  = kind;
    c.x_pos      = 24'(x);
    c.y_pos      = 24'(y);
    c.rect_w     = 24'(w);
    c.rect_h     = 24'(h);
    c.paint_char = paint;
    c.read_x     = 8'(qx);
    c.read_y     = 8'(qy);
    return c;
  endfunction

  // Mostly well-formed draws near the canvas and in-range reads; the rest
  // is raw noise, rejected draws, clears and the unused op.
  function automatic canvas_cmd_t random_cmd();
    canvas_cmd_t c;
    logic [159:0] noise;
    int w, h, pick;
    w     = tracker.side(tracker.width_reg);
    h     = tracker.side(tracker.height_reg);
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    c     = noise[$bits(canvas_cmd_t)-1:0];
    pick  = $urandom_range(99);
    if (pick < 8) begin
      c.op = OP_CLEAR;
    end else if (pick < 50) begin
      c.op        = OP_DRAW;
      c.rect_kind = $urandom_range(1) ? KIND_FILLED : KIND_OUTLINE;
      c.x_pos     = 24'($urandom_range((w + 4) * UNIT) - 2 * UNIT);
      c.y_pos     = 24'($urandom_range((h + 4) * UNIT) - 2 * UNIT);
      c.rect_w    = 24'($urandom_range((w + 2) * UNIT, 1));
      c.rect_h    = 24'($urandom_range((h + 2) * UNIT, 1));
    end else if (pick < 58) begin
      c.op = OP_DRAW;
    end else if (pick < 66) begin
      c.op        = OP_DRAW;
      c.rect_kind = $urandom_range(1) ? KIND_FILLED : KIND_OUTLINE;
      if ($urandom_range(1)) c.rect_w = 24'(-int'($urandom_range(3 * UNIT)));
      else                   c.rect_h = 24'(-int'($urandom_range(3 * UNIT)));
    end else if (pick < 95) begin
      c.op = OP_READ;
      if ($urandom_range(9) < 7) begin
        c.read_x = 8'($urandom_range(w - 1));
        c.read_y = 8'($urandom_range(h - 1));
      end
    end else begin
      c.op = OP_UNUSED;
    end
    // never read a cell that was not written since power-up
    if (c.op == OP_READ && !tracker.readable(c.read_x, c.read_y)) c.op = OP_UNUSED;
    return c;
  endfunction

  // Called at a falling edge, returns at a falling edge with tvalid still up
  task automatic send_cmd(input canvas_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - $bits(canvas_cmd_t)){1'b0}}, c};
    do @(posedge clk); while (!s_tready);
    tracker.note_command(c);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_cmd(random_cmd());
  endtask

  // Stop offering and wait until every owed result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Only called with the block idle
  task automatic write_canvas_cfg(input int w, input int h, input int bg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CANVAS_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    tracker.set_reg(CFG_CANVAS_WIDTH, CFG_DATA_W'(w));
    @(negedge clk);
    cfg_index <= CFG_CANVAS_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    tracker.set_reg(CFG_CANVAS_HEIGHT, CFG_DATA_W'(h));
    @(negedge clk);
    cfg_index <= CFG_BACKGROUND_CHAR;
    cfg_data  <= CFG_DATA_W'(bg);
    tracker.set_reg(CFG_BACKGROUND_CHAR, CFG_DATA_W'(bg));
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    tracker          = new();
    hold_off_request = 1'b0;
    stall_cycles     = 0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    set_idling(0, 0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: 1x1 canvas, space background
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 1, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 0, 1));
    send_cmd(make_cmd(OP_UNUSED, 8'hFF, -1, -1, -1, -1, 8'hFF, 255, 255));
    drain();

    // Directed: 8x6 canvas
    write_canvas_cfg(8, 6, 8'h2E);
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_cmd(make_cmd(OP_DRAW, KIND_FILLED, UNIT, UNIT, 3 * UNIT, 2 * UNIT, 8'h23, 0, 0));
    // fractional outline, bottom edge on a pixel center, the other edges between
    send_cmd(make_cmd(OP_DRAW, KIND_OUTLINE, 'h80, 'h80, 6 * UNIT + 'h40, 4 * UNIT + 'h80,
                      8'h6F, 0, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 4, 1));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 1, 1));
    // rejected: zero width, negative height, bad kinds
    send_cmd(make_cmd(OP_DRAW, KIND_FILLED, 0, 0, 0, UNIT, 8'h55, 0, 0));
    send_cmd(make_cmd(OP_DRAW, KIND_OUTLINE, 0, 0, UNIT, -1, 8'h55, 0, 0));
    send_cmd(make_cmd(OP_DRAW, 8'h00, 0, 0, UNIT, UNIT, 8'h55, 0, 0));
    send_cmd(make_cmd(OP_DRAW, 8'hFF, 0, 0, -8388608, UNIT, 8'h55, 0, 0));
    // coordinate extremes: right edge ends just below zero, paints nothing
    send_cmd(make_cmd(OP_DRAW, KIND_FILLED, -8388608, -8388608, 8388607, 8388607,
                      8'hAA, 0, 0));
    send_cmd(make_cmd(OP_DRAW, KIND_FILLED, 0, 0, 8388607, 8388607, 8'hFF, 0, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 7, 5));
    // reads outside the canvas
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 8, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 255, 255));
    send_cmd(make_cmd(OP_DRAW, KIND_OUTLINE, -'h80, 2 * UNIT, UNIT, UNIT, 8'h00, 0, 0));
    // one-LSB wide outline column
    send_cmd(make_cmd(OP_DRAW, KIND_OUTLINE, 3 * UNIT, 0, 1, 8388607, 8'h7C, 0, 0));
    send_cmd(make_cmd(OP_DRAW, KIND_FILLED, 8388607, 0, 1, UNIT, 8'h01, 0, 0));
    send_cmd(make_cmd(OP_UNUSED, KIND_FILLED, 0, 0, UNIT, UNIT, 8'h01, 0, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 3, 2));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 0, 2));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 3, 0));
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 5, 5));
    drain();

    // Random on a 16x12 canvas, sender idling
    write_canvas_cfg(16, 12, 8'h00);
    set_idling(65, 0);
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_random(15);
    drain();

    // Out-of-range size registers: width 0 -> 1, height 300 -> 256
    write_canvas_cfg(0, 300, 8'hFF);
    set_idling(0, 65);
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_random(10);
    drain();

    // Width change without a clear: old bytes are re-addressed with the new width
    write_canvas_cfg(300, 3, $urandom_range(255));
    set_idling(38, 38);
    send_random(15);
    drain();

    // Full 256x256 canvas, a few long sweeps
    write_canvas_cfg(256, 256, 8'h41);
    set_idling(0, 65);
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_cmd(make_cmd(OP_DRAW, KIND_FILLED, 10 * UNIT + 'h10, 20 * UNIT, 200 * UNIT,
                      100 * UNIT + 'h7F, 8'h58, 0, 0));
    send_cmd(make_cmd(OP_DRAW, KIND_OUTLINE, -5 * UNIT, 100 * UNIT, 300 * UNIT,
                      155 * UNIT, 8'h2A, 0, 0));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 255, 255));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 10, 20));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 0, 100));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 128, 101));
    send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 0, 0, 8'h00, 9, 19));
    send_cmd(make_cmd(OP_DRAW, KIND_FILLED, 0, 0, UNIT, -8388608, 8'h00, 0, 0));
    drain();

    // 31x17: long output hold-off so the block backs up into its input
    write_canvas_cfg(31, 17, $urandom_range(255));
    set_idling(0, 0);
    hold_off_request = 1'b1;
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_random(12);
    drain();
    set_idling(65, 0);
    send_random(12);
    drain();

    // Back to a single pixel
    write_canvas_cfg(1, 1, 8'h00);
    set_idling(38, 38);
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
    send_random(8);
    drain();

    repeat (20) @(posedge clk);
    if (tracker.error_count == 0 && tracker.pending_results.size() == 0)
      $display("rectangle_canvas_painter_core_tb: PASS");
    else
      $display("rectangle_canvas_painter_core_tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
sv/rcp_pkg.sv
sv/rcp_ram.sv
sv/rcp_axis_cmp.sv
sv/rectangle_canvas_painter_core.sv
verif/rectangle_canvas_painter_core_tb.sv
